[sv/asa_pkg.sv]
// ----------------------------------------------------------------------------
// asa_pkg
// Types and constants that the aligned stack allocator files share.
// ----------------------------------------------------------------------------
package asa_pkg;

	localparam int BASE_W  = 32;  // base address and free address
	localparam int POOL_W  = 33;  // pool size, used bytes
	localparam int SIZE_W  = 33;  // request size
	localparam int TOP_W   = 34;  // top address: base plus at most a full pool
	localparam int SUM_W   = 35;  // top or used plus padding plus size
	localparam int ALIGN_W = 3;   // log2 of alignment
	localparam int DATA_W  = 64;  // APB data
	localparam int PADDR_W = 4;   // registers at byte 0 and 8

	localparam logic [POOL_W-1:0] POOL_RESET = 33'd65536;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_SPACE = 2'd1,
		STS_BAD_FREE = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		REG_BASE = 1'b0,
		REG_POOL = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [POOL_W-1:0] pool;
		logic              clear;
	} asa_cfg_t;

endpackage

[sv/asa_ram.sv]
// ----------------------------------------------------------------------------
// asa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module asa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/asa_regs.sv]
// ----------------------------------------------------------------------------
// asa_regs
// APB register file: base address and pool size, with a clear pulse on write.
// ----------------------------------------------------------------------------
module asa_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [asa_pkg::PADDR_W-1:0]   paddr,
	input  logic [asa_pkg::DATA_W-1:0]    pwdata,
	output logic [asa_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output asa_pkg::asa_cfg_t             cfg
);
	import asa_pkg::*;

	logic [BASE_W-1:0] base_q;
	logic [POOL_W-1:0] pool_q;
	logic              clear_q;
	logic              wr;
	reg_sel_t          sel;

	assign sel    = reg_sel_t'(paddr[PADDR_W-1]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			pool_q  <= POOL_RESET;
			clear_q <= 1'b0;
		end else begin
			clear_q <= wr;
			if (wr) begin
				unique case (sel)
					REG_BASE: base_q <= pwdata[BASE_W-1:0];
					REG_POOL: pool_q <= pwdata[POOL_W-1:0];
					default:  base_q <= base_q;
				endcase
			end
		end
	end

	always_comb begin
		unique case (sel)
			REG_BASE: prdata = DATA_W'(base_q);
			REG_POOL: prdata = DATA_W'(pool_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.base  = base_q;
	assign cfg.pool  = pool_q;
	assign cfg.clear = clear_q;

endmodule

[sv/aligned_stack_allocator.sv]
// ----------------------------------------------------------------------------
// aligned_stack_allocator
// Bump allocator with aligned blocks and a stack of live blocks for LIFO free.
// ----------------------------------------------------------------------------
// A request passes the idle, evaluate and commit states: the accept cycle
// issues the read of the newest stack entry, evaluate computes the padding
// and the new top and used sums and compares the stack entry, and commit
// checks space and commits, writing the stack memory and loading the result
// register. The result register frees the input side once it is taken, so a
// new request is accepted in the cycle the previous result is taken. The stack
// lives in one MAX_BLOCKS-deep RAM (one write and one read port); entries are
// only read below the live count, so it needs no clearing pass after reset.
// Writing either register clears the allocator in the cycle after the write.
// used_bytes and live_count show the allocator state after the last request.
// ----------------------------------------------------------------------------
module aligned_stack_allocator #(
	parameter int ADDR_BITS    = 32,
	parameter int MAX_BLOCKS   = 256,
	parameter int HEADER_BYTES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         command,
	input  logic [asa_pkg::SIZE_W-1:0]         request_size,
	input  logic [asa_pkg::ALIGN_W-1:0]        align_log2,
	input  logic [asa_pkg::BASE_W-1:0]         free_address,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [asa_pkg::BASE_W-1:0]         result_address,
	output logic [1:0]                         status,
	output logic [asa_pkg::POOL_W-1:0]         used_bytes,
	output logic [$clog2(MAX_BLOCKS+1)-1:0]    live_count,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [asa_pkg::PADDR_W-1:0]        paddr,
	input  logic [asa_pkg::DATA_W-1:0]         pwdata,
	output logic [asa_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);
	import asa_pkg::*;

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int PAD_W = $clog2(HEADER_BYTES + 256);
	localparam int ENT_W = TOP_W + PAD_W;
	localparam int CMP_W = (ADDR_BITS + 1 > SUM_W) ? ADDR_BITS + 1 : SUM_W;
	localparam logic [CMP_W-1:0] LIMIT  = CMP_W'(1) << ADDR_BITS;
	localparam logic [PAD_W-1:0] HDR    = PAD_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EVAL   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q;

	// allocator state
	logic [TOP_W-1:0]  top_q;
	logic [POOL_W-1:0] used_q;
	logic [CNT_W-1:0]  count_q;

	// request held for its whole run
	cmd_t               cmd_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ALIGN_W-1:0] lg_q;
	logic [BASE_W-1:0]  free_q;

	// evaluation results
	logic [PAD_W-1:0]   pad_q;
	logic [TOP_W-1:0]   aligned_q;
	logic [SUM_W-1:0]   sum_used_q;
	logic [SUM_W-1:0]   blk_end_q;
	logic [TOP_W-1:0]   free_top_q;
	logic               match_q;

	// result register
	logic               out_valid_q;
	logic [BASE_W-1:0]  result_q;
	status_t            status_q;

	asa_cfg_t           cfg;

	logic               accept;
	logic [CNT_W-1:0]   cnt_dec;
	logic               ram_we;
	logic [ENT_W-1:0]   ram_rdata;

	// padding logic
	logic [PAD_W-1:0]   align;
	logic [PAD_W-1:0]   mask;
	logic [PAD_W-1:0]   adj0;
	logic [PAD_W-1:0]   need;
	logic [PAD_W-1:0]   pad;
	logic [TOP_W-1:0]   ent_addr;
	logic [PAD_W-1:0]   ent_pad;

	asa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Take a request only with the sequencer idle and the result slot free.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign cnt_dec  = count_q - CNT_W'(1);

	// Stack memory: newest entry read on accept, pushed on a good allocate.
	asa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_BLOCKS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({aligned_q, pad_q}),
		.re    (accept),
		.raddr (cnt_dec[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign ent_addr = ram_rdata[ENT_W-1:PAD_W];
	assign ent_pad  = ram_rdata[PAD_W-1:0];

	// Padding: distance to the next aligned address, then grow by whole
	// alignment steps until the header fits.
	always_comb begin
		align = PAD_W'(1) << lg_q;
		mask  = align - PAD_W'(1);
		adj0  = (align - (top_q[PAD_W-1:0] & mask)) & mask;
		need  = HDR - adj0;
		pad   = adj0;
		if (adj0 < HDR) begin
			pad = adj0 + (((need + mask) >> lg_q) << lg_q);
		end
	end

	// Push only on an allocate that passes both the full and space checks.
	always_comb begin
		ram_we = 1'b0;
		if (state_q == ST_COMMIT && cmd_q == CMD_ALLOC && count_q != CNT_MAX &&
			sum_used_q <= SUM_W'(cfg.pool) && CMP_W'(blk_end_q) <= LIMIT) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= '0;
			used_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
					case (cmd_q)
						CMD_ALLOC: begin
							if (ram_we) begin
								top_q   <= blk_end_q[TOP_W-1:0];
								used_q  <= sum_used_q[POOL_W-1:0];
								count_q <= count_q + CNT_W'(1);
							end
						end
						CMD_FREE: begin
							if (free_q != '0 && match_q) begin
								top_q   <= free_top_q;
								used_q  <= POOL_W'(free_top_q - TOP_W'(cfg.base));
								count_q <= cnt_dec;
							end
						end
						CMD_CLEAR: begin
							top_q   <= TOP_W'(cfg.base);
							used_q  <= '0;
							count_q <= '0;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// register write: drop all blocks, top back to the new base
			if (cfg.clear) begin
				top_q   <= TOP_W'(cfg.base);
				used_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// Payload registers: request capture, evaluation, result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(command);
			size_q <= request_size;
			lg_q   <= align_log2;
			free_q <= free_address;
		end
		if (state_q == ST_EVAL) begin
			pad_q      <= pad;
			aligned_q  <= top_q + TOP_W'(pad);
			sum_used_q <= SUM_W'(used_q) + SUM_W'(pad) + SUM_W'(size_q);
			blk_end_q  <= SUM_W'(top_q) + SUM_W'(pad) + SUM_W'(size_q);
			free_top_q <= ent_addr - TOP_W'(ent_pad);
			match_q    <= (count_q != '0) && (ent_addr == TOP_W'(free_q));
		end
		if (state_q == ST_COMMIT) begin
			result_q <= '0;
			status_q <= STS_OK;
			case (cmd_q)
				CMD_ALLOC: begin
					if (count_q == CNT_MAX) begin
						status_q <= STS_FULL;
					end else if (!ram_we) begin
						status_q <= STS_NO_SPACE;
					end else begin
						result_q <= aligned_q[BASE_W-1:0];
					end
				end
				CMD_FREE: begin
					if (free_q != '0 && !match_q) begin
						status_q <= STS_BAD_FREE;
					end
				end
				default: begin
					status_q <= STS_OK;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = result_q;
	assign status         = status_q;
	assign used_bytes     = used_q;
	assign live_count     = count_q;

endmodule

[test/aligned_stack_allocator_checker.sv]
// ----------------------------------------------------------------------------
// aligned_stack_allocator_checker
// Predicts every allocator response from the accepted requests and register
// writes, and compares each taken response with the oldest prediction.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_checker #(
	parameter int ADDR_BITS    = 32,
	parameter int MAX_BLOCKS   = 256,
	parameter int HEADER_BYTES = 8,
	parameter int CNT_W        = $clog2(MAX_BLOCKS+1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   command,
	input  logic [asa_pkg::SIZE_W-1:0]   request_size,
	input  logic [asa_pkg::ALIGN_W-1:0]  align_log2,
	input  logic [asa_pkg::BASE_W-1:0]   free_address,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [asa_pkg::BASE_W-1:0]   result_address,
	input  logic [1:0]                   status,
	input  logic [asa_pkg::POOL_W-1:0]   used_bytes,
	input  logic [CNT_W-1:0]             live_count,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [asa_pkg::PADDR_W-1:0]  paddr,
	input  logic [asa_pkg::DATA_W-1:0]   pwdata,
	output int unsigned                  errors,
	output int unsigned                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import asa_pkg::*;

	localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << ADDR_BITS;
	localparam int unsigned      MAX_PRINTS = 100;

	typedef struct {
		logic [SUM_W-1:0] addr;
		logic [7:0]       pad;
	} live_block_t;

	typedef struct {
		logic [BASE_W-1:0] addr;
		status_t           st;
		logic [POOL_W-1:0] used;
		logic [CNT_W-1:0]  live;
	} alloc_result_t;

	logic [BASE_W-1:0] base_q;
	logic [POOL_W-1:0] pool_q;
	logic [SUM_W-1:0]  top_q;
	logic [SUM_W-1:0]  used_q;
	int unsigned       nblk;
	live_block_t       blocks [MAX_BLOCKS];
	alloc_result_t     response_q [$];
	alloc_result_t     want;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		// keep the log short when the block is badly broken
		if (errors < MAX_PRINTS)
			$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
				exp_val);
		errors = errors + 1;
	endtask

	// smallest padding of at least the header size that aligns the top
	function automatic int unsigned header_pad(input logic [SUM_W-1:0] top,
			input logic [ALIGN_W-1:0] lg);
		int unsigned align;
		int unsigned mis;
		int unsigned adj;
		align = 1 << lg;
		mis = 32'(top[7:0]) & (align - 1);
		adj = (mis != 0) ? align - mis : 0;
		if (adj < HEADER_BYTES)
			adj += align * ((HEADER_BYTES - adj + align - 1) / align);
		return adj;
	endfunction

	function automatic void drop_all_blocks();
		top_q = SUM_W'(base_q);
		used_q = '0;
		nblk = 0;
	endfunction

	function automatic alloc_result_t predict_response(input cmd_t c,
			input logic [SIZE_W-1:0] sz, input logic [ALIGN_W-1:0] lg,
			input logic [BASE_W-1:0] fa);
		alloc_result_t r;
		logic [SUM_W-1:0] pad;
		logic [SUM_W-1:0] aligned;
		logic [SUM_W-1:0] tail;
		r.addr = '0;
		r.st = STS_OK;
		case (c)
		CMD_ALLOC: begin
			if (nblk >= MAX_BLOCKS) begin
				r.st = STS_FULL;
			end else begin
				pad = SUM_W'(header_pad(top_q, lg));
				aligned = top_q + pad;
				tail = aligned + SUM_W'(sz);
				if (used_q + pad + SUM_W'(sz) > SUM_W'(pool_q) || tail > ADDR_LIMIT) begin
					r.st = STS_NO_SPACE;
				end else begin
					blocks[nblk].addr = aligned;
					blocks[nblk].pad = pad[7:0];
					nblk++;
					top_q = tail;
					used_q = used_q + pad + SUM_W'(sz);
					r.addr = aligned[BASE_W-1:0];
				end
			end
		end
		CMD_FREE: begin
			if (fa != '0) begin
				if (nblk == 0) begin
					r.st = STS_BAD_FREE;
				end else if (blocks[nblk-1].addr != SUM_W'(fa)) begin
					r.st = STS_BAD_FREE;
				end else begin
					top_q = blocks[nblk-1].addr - SUM_W'(blocks[nblk-1].pad);
					used_q = top_q - SUM_W'(base_q);
					nblk--;
				end
			end
		end
		CMD_CLEAR: begin
			drop_all_blocks();
		end
		default: begin
		end
		endcase
		r.used = used_q[POOL_W-1:0];
		r.live = CNT_W'(nblk);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q = '0;
			pool_q = POOL_RESET;
			drop_all_blocks();
			response_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2:0] == 3'b000) begin
				if (reg_sel_t'(paddr[3]) == REG_BASE)
					base_q = pwdata[BASE_W-1:0];
				else
					pool_q = pwdata[POOL_W-1:0];
				drop_all_blocks();
			end
			if (out_valid && out_ready) begin
				if (response_q.size() == 0) begin
					report_mismatch("unexpected response", 64'(result_address), '0);
				end else begin
					want = response_q.pop_front();
					if (result_address !== want.addr)
						report_mismatch("result_address", 64'(result_address), 64'(want.addr));
					if (status !== want.st)
						report_mismatch("status", 64'(status), 64'(want.st));
					if (used_bytes !== want.used)
						report_mismatch("used_bytes", 64'(used_bytes), 64'(want.used));
					if (live_count !== want.live)
						report_mismatch("live_count", 64'(live_count), 64'(want.live));
				end
			end
			if (in_valid && in_ready)
				response_q.push_back(predict_response(cmd_t'(command), request_size,
					align_log2, free_address));
			pending <= response_q.size();
		end
	end

endmodule

[test/aligned_stack_allocator_tb.sv]
// ----------------------------------------------------------------------------
// aligned_stack_allocator_tb
// Drives allocate, free, clear and unused requests through the allocator
// under several base and pool settings, with random stalls on both sides.
// A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import asa_pkg::*;

	localparam int ADDR_BITS    = 32;
	localparam int MAX_BLOCKS   = 256;
	localparam int HEADER_BYTES = 8;
	localparam int CNT_W        = $clog2(MAX_BLOCKS+1);

	localparam int unsigned N_ITEMS     = 1500;  // rough request count, sets the idle phases
	localparam int unsigned HOLD_CYCLES = 250;   // long receiver stall
	localparam int unsigned HOLD_AT_A   = 100;   // responses taken before each long stall
	localparam int unsigned HOLD_AT_B   = 1100;
	localparam int unsigned SETTLE      = 10;    // wait after the drain for a late extra response
	localparam longint      LIMIT_NS    = 4_000_000;

	// how a free request picks its address
	typedef enum {
		FREE_LAST,   // newest live block, after the allocator went idle
		FREE_RACE,   // newest block as known right now, may be stale
		FREE_NULL,   // null address
		FREE_STRAY,  // random address
		FREE_OLDER   // a live block below the newest
	} free_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           command = CMD_NONE;
	logic [SIZE_W-1:0]    request_size = '0;
	logic [ALIGN_W-1:0]   align_log2 = '0;
	logic [BASE_W-1:0]    free_address = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BASE_W-1:0]    result_address;
	logic [1:0]           status;
	logic [POOL_W-1:0]    used_bytes;
	logic [CNT_W-1:0]     live_count;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	int unsigned          errors;
	int unsigned          pending;

	// what the stimulus knows of the live blocks, learned from taken responses
	logic [BASE_W-1:0]    live_addr [MAX_BLOCKS];
	int unsigned          live_len = 0;
	logic [POOL_W-1:0]    last_used = '0;
	logic [POOL_W-1:0]    cur_pool = POOL_RESET;

	int unsigned          n_issued = 0;
	int unsigned          taken = 0;
	int unsigned          hold_left = 0;

	aligned_stack_allocator #(
		.ADDR_BITS    (ADDR_BITS),
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.request_size   (request_size),
		.align_log2     (align_log2),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_address (result_address),
		.status         (status),
		.used_bytes     (used_bytes),
		.live_count     (live_count),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	aligned_stack_allocator_checker #(
		.ADDR_BITS    (ADDR_BITS),
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.request_size   (request_size),
		.align_log2     (align_log2),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_address (result_address),
		.status         (status),
		.used_bytes     (used_bytes),
		.live_count     (live_count),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.errors         (errors),
		.pending        (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle share in percent: one value for the first third of the run, another
	// for the second third, none for the rest.
	function automatic int unsigned idle_pct(input int unsigned n, input int unsigned first,
			input int unsigned second);
		if (n < N_ITEMS / 3)
			return first;
		if (n < 2 * N_ITEMS / 3)
			return second;
		return 0;
	endfunction

	// Receiver: stall at random, hold off for a long stretch twice so that the
	// allocator backs up onto its request side, and track the live blocks.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				taken = taken + 1;
				last_used <= used_bytes;
				live_len <= live_count;
				// a nonzero address only comes back from a successful allocate
				if (result_address != '0 && live_count != 0)
					live_addr[live_count-1] <= result_address;
				if (taken == HOLD_AT_A || taken == HOLD_AT_B)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct(taken, 57, 30));
			end
		end
	end

	// Drop valid and wait until every predicted response was taken. Advance past
	// the current edge first so that a request accepted at this edge is counted.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Offer one request after a random gap and hold it until accepted. Valid
	// stays high on return; the next call either reuses it or drops it.
	task automatic push_request(input cmd_t c, input logic [SIZE_W-1:0] sz,
			input logic [ALIGN_W-1:0] lg, input logic [BASE_W-1:0] fa);
		while ($urandom_range(99) < idle_pct(n_issued, 30, 57)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		request_size <= sz;
		align_log2 <= lg;
		free_address <= fa;
		do
			@(posedge clk);
		while (!in_ready);
		n_issued++;
	endtask

	// Register write in a setup and an access cycle, only with the allocator
	// idle. Wait afterwards so that the clear that follows it lands.
	task automatic apb_write(input reg_sel_t r, input logic [DATA_W-1:0] v);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic issue_free(input free_kind_t k);
		logic [BASE_W-1:0] fa;
		// wait for the newest address only for the well-formed release
		if (k == FREE_LAST)
			wait_idle();
		case (k)
		FREE_LAST, FREE_RACE: begin
			fa = (live_len != 0) ? live_addr[live_len-1] : BASE_W'($urandom);
		end
		FREE_NULL: begin
			fa = '0;
		end
		FREE_OLDER: begin
			fa = (live_len > 1) ? live_addr[$urandom_range(live_len-2)] : BASE_W'($urandom);
		end
		default: begin
			fa = BASE_W'($urandom);
		end
		endcase
		// fill the unused fields with noise
		push_request(CMD_FREE, SIZE_W'({$urandom, $urandom}), ALIGN_W'($urandom), fa);
	endtask

	task automatic random_request();
		int unsigned pick;
		int unsigned sub;
		logic [SIZE_W-1:0] sz;
		logic [SIZE_W-1:0] room;
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		if (pick < 52) begin
			room = (cur_pool > last_used) ? cur_pool - last_used : '0;
			// mostly small blocks; some aimed at the remaining room to hit
			// the exact-fit edge, a few at random over the full field
			if (sub < 55)
				sz = SIZE_W'($urandom_range(64));
			else if (sub < 75)
				sz = SIZE_W'($urandom_range(4096));
			else if (sub < 90)
				sz = (room > 150) ? room - SIZE_W'($urandom_range(150))
					: SIZE_W'($urandom_range(150));
			else
				sz = SIZE_W'({$urandom, $urandom});
			push_request(CMD_ALLOC, sz, ALIGN_W'($urandom_range(7)), BASE_W'($urandom));
		end else if (pick < 92) begin
			if (sub < 55)
				issue_free(FREE_LAST);
			else if (sub < 70)
				issue_free(FREE_RACE);
			else if (sub < 80)
				issue_free(FREE_NULL);
			else if (sub < 90)
				issue_free(FREE_STRAY);
			else
				issue_free(FREE_OLDER);
		end else if (pick < 96) begin
			push_request(CMD_CLEAR, SIZE_W'({$urandom, $urandom}), ALIGN_W'($urandom),
				BASE_W'($urandom));
		end else begin
			push_request(CMD_NONE, SIZE_W'({$urandom, $urandom}), ALIGN_W'($urandom),
				BASE_W'($urandom));
		end
	endtask

	initial begin
		logic [BASE_W-1:0] nb;
		logic [POOL_W-1:0] np;
		int unsigned       n_rand;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings: base 0, 64 KiB pool.
		// Empty allocator: null free, stray free, unused command with all ones.
		issue_free(FREE_NULL);
		push_request(CMD_FREE, '0, '0, 32'h0000_0100);
		push_request(CMD_NONE, {SIZE_W{1'b1}}, {ALIGN_W{1'b1}}, {BASE_W{1'b1}});
		// zero size still takes the header padding; then the widest alignment
		push_request(CMD_ALLOC, '0, 3'd0, '0);
		push_request(CMD_ALLOC, 33'd1, 3'd7, '0);
		push_request(CMD_ALLOC, 33'd100, 3'd3, '0);
		// release out of order, then newest first
		issue_free(FREE_OLDER);
		issue_free(FREE_LAST);
		issue_free(FREE_LAST);
		// far too large, then exactly the pool on top of the live block
		push_request(CMD_ALLOC, {SIZE_W{1'b1}}, 3'd7, '0);
		push_request(CMD_ALLOC, 33'd65536, 3'd0, '0);
		push_request(CMD_CLEAR, '0, '0, '0);
		// fill the pool to the last byte; a zero size no longer fits
		push_request(CMD_ALLOC, SIZE_W'(POOL_RESET - HEADER_BYTES), 3'd0, '0);
		push_request(CMD_ALLOC, '0, 3'd0, '0);
		issue_free(FREE_LAST);
		// now empty again: this one must be refused unless it happens to be null
		issue_free(FREE_LAST);
		push_request(CMD_CLEAR, '0, '0, '0);

		// Random phases, each under its own base and pool setting.
		for (int p = 0; p < 8; p++) begin
			case (p)
			0: begin nb = 32'h0000_1003; np = 33'd65536;       n_rand = 120; end
			1: begin nb = 32'h0000_0000; np = 33'h1_0000_0000; n_rand = 200; end
			2: begin nb = 32'hFFFF_F000; np = 33'h1_0000_0000; n_rand = 120; end
			3: begin nb = 32'hFFFF_FFFF; np = 33'h1_0000_0000; n_rand = 50;  end
			4: begin nb = $urandom;      np = 33'd1;           n_rand = 50;  end
			5: begin nb = $urandom;      np = POOL_W'($urandom_range(1, 1 << 20));
				n_rand = 200; end
			6: begin nb = 32'h8000_0007; np = POOL_W'($urandom) + 1'b1; n_rand = 200; end
			default: begin nb = 32'h0000_0000; np = POOL_RESET; n_rand = 120; end
			endcase
			apb_write(REG_BASE, DATA_W'(nb));
			apb_write(REG_POOL, DATA_W'(np));
			cur_pool = np;
			if (p == 0) begin
				// fill the stack past its depth with small blocks, then unwind
				// it newest first and run two frees on the empty stack
				repeat (MAX_BLOCKS + 6)
					push_request(CMD_ALLOC, SIZE_W'($urandom_range(31)),
						ALIGN_W'($urandom_range(4)), BASE_W'($urandom));
				repeat (MAX_BLOCKS + 2)
					issue_free(FREE_LAST);
			end
			repeat (n_rand)
				random_request();
		end

		// drain, then give a late extra response the chance to show up
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(LIMIT_NS * 1ns);
		$display("FAILURE");
		$finish;
	end

endmodule
